// File: design/bspline_tile_knot_indexer_defines.svh
// Assertion macros shared by the knot indexer RTL.
// Self-contained; expects signals named clock and reset in the including scope.
`ifndef BSPLINE_TILE_KNOT_INDEXER_DEFINES_SVH
`define BSPLINE_TILE_KNOT_INDEXER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BTKI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTKI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/btki_pkg.sv
// Shared types, constants and helpers for the B-spline tile knot indexer.
// No dependencies.
package btki_pkg;

   localparam int TILE_W           = 24;
   localparam int KNOT_W           = 24;
   localparam int DIM_W            = 9;
   localparam int DXDY_W           = 2 * DIM_W;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 32;
   localparam int DEF_MAX_GRID_DIM = 256;
   localparam int SPAN             = 4;
   localparam int MARGIN           = 3;
   localparam int KNOTS_PER_TILE   = SPAN * SPAN * SPAN;
   localparam int CNT_W            = $clog2(KNOTS_PER_TILE);
   localparam int DIV_BITS         = 2;
   localparam int DIV_STEPS        = TILE_W / DIV_BITS;
   localparam int STEP_W           = $clog2(DIV_STEPS);

   // Register indexes within the CSR space
   localparam logic [1:0] REG_GRID_DIM_X = 2'd0;
   localparam logic [1:0] REG_GRID_DIM_Y = 2'd1;
   localparam logic [1:0] REG_GRID_DIM_Z = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] dx;
      logic [DIM_W-1:0] dy;
      logic [DIM_W-1:0] nx;
      logic [DIM_W-1:0] ny;
      logic [DIM_W-1:0] nz;
   } btki_dims_type;

   typedef struct packed {
      logic [KNOT_W-1:0] base;
      logic [DIM_W-1:0]  dx;
      logic [DXDY_W-1:0] dxdy;
   } btki_tile_type;

   typedef struct packed {
      logic full;
      logic empty;
   } btki_qstat_type;

   // Clamp a raw dimension register into SPAN..max_dim
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                input int max_dim);
      logic [DIM_W-1:0] d;
      d = raw;
      if (raw < DIM_W'(SPAN)) begin
         d = DIM_W'(SPAN);
      end else if (32'(raw) > max_dim) begin
         d = DIM_W'(max_dim);
      end
      return d;
   endfunction

endpackage

// File: design/btki_csr.sv
// Configuration registers on an APB-style port, plus effective grid sizes.
// Depends on btki_pkg.
module btki_csr #(
   parameter int MAX_GRID_DIM = btki_pkg::DEF_MAX_GRID_DIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [btki_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [btki_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [btki_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output btki_pkg::btki_dims_type           dims
);
   import btki_pkg::*;

   logic [DIM_W-1:0] dim_x_ff, dim_x_in;
   logic [DIM_W-1:0] dim_y_ff, dim_y_in;
   logic [DIM_W-1:0] dim_z_ff, dim_z_in;
   logic [1:0]       reg_sel;
   logic             wr_en;
   logic [DIM_W-1:0] dx, dy, dz;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      dim_x_in = dim_x_ff;
      dim_y_in = dim_y_ff;
      dim_z_in = dim_z_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_GRID_DIM_X: dim_x_in = csr_pwdata[DIM_W-1:0];
            REG_GRID_DIM_Y: dim_y_in = csr_pwdata[DIM_W-1:0];
            REG_GRID_DIM_Z: dim_z_in = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_W'(SPAN);
         dim_y_ff <= DIM_W'(SPAN);
         dim_z_ff <= DIM_W'(SPAN);
      end else begin
         dim_x_ff <= dim_x_in;
         dim_y_ff <= dim_y_in;
         dim_z_ff <= dim_z_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GRID_DIM_X: csr_prdata = CSR_DATA_W'(dim_x_ff);
         REG_GRID_DIM_Y: csr_prdata = CSR_DATA_W'(dim_y_ff);
         REG_GRID_DIM_Z: csr_prdata = CSR_DATA_W'(dim_z_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign dx = eff_dim(dim_x_ff, MAX_GRID_DIM);
   assign dy = eff_dim(dim_y_ff, MAX_GRID_DIM);
   assign dz = eff_dim(dim_z_ff, MAX_GRID_DIM);

   assign dims.dx = dx;
   assign dims.dy = dy;
   assign dims.nx = dx - DIM_W'(MARGIN);
   assign dims.ny = dy - DIM_W'(MARGIN);
   assign dims.nz = dz - DIM_W'(MARGIN);

endmodule

// File: design/btki_front.sv
// Front end: accepts a tile word, splits it into tile coordinates with a
// two-bit-per-cycle divider and forms the base knot index. Depends on btki_pkg.
module btki_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [btki_pkg::TILE_W-1:0]       req_tile_number,
   output logic                              req_stall,
   input  btki_pkg::btki_dims_type           dims,
   input  btki_pkg::btki_qstat_type          q_stat,
   output logic                              q_push,
   output btki_pkg::btki_tile_type           q_entry
);
   import btki_pkg::*;

   typedef enum logic [2:0] {F_IDLE, F_DIV, F_MUL1, F_MUL2, F_PUSH} fstate_type;
   typedef enum logic [1:0] {PH_X, PH_Y, PH_Z} phase_type;

   fstate_type        state_ff;
   phase_type         phase_ff;
   logic [STEP_W-1:0] step_ff;
   logic [TILE_W-1:0] dvd_ff;
   logic [DIM_W-1:0]  rem_ff;
   logic [DIM_W-1:0]  tx_ff, ty_ff, tz_ff;
   logic [DXDY_W-1:0] dxdy_ff, rowoff_ff;
   logic [KNOT_W-1:0] base_ff;

   logic [DIM_W-1:0]  divisor;
   logic [DIM_W-1:0]  div_rem;
   logic [TILE_W-1:0] div_dvd;
   logic              accept;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      unique case (phase_ff)
         PH_X:    divisor = dims.nx;
         PH_Y:    divisor = dims.ny;
         PH_Z:    divisor = dims.nz;
         default: divisor = dims.nz;
      endcase
   end

   // Restoring division, quotient bits shift in behind the dividend
   always_comb begin
      logic [DIM_W:0]    trial;
      logic [DIM_W-1:0]  r;
      logic [TILE_W-1:0] q;
      r = rem_ff;
      q = dvd_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, q[TILE_W-1]};
         q     = {q[TILE_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            r    = DIM_W'(trial - {1'b0, divisor});
            q[0] = 1'b1;
         end else begin
            r = trial[DIM_W-1:0];
         end
      end
      div_rem = r;
      div_dvd = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= PH_X;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= F_DIV;
                  phase_ff <= PH_X;
                  step_ff  <= '0;
               end
            end
            F_DIV: begin
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  step_ff <= '0;
                  unique case (phase_ff)
                     PH_X:    phase_ff <= PH_Y;
                     PH_Y:    phase_ff <= PH_Z;
                     default: state_ff <= F_MUL1;
                  endcase
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            F_MUL1: state_ff <= F_MUL2;
            F_MUL2: state_ff <= F_PUSH;
            F_PUSH: begin
               if (!q_stat.full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         dvd_ff <= req_tile_number;
         rem_ff <= '0;
      end else if (state_ff == F_DIV) begin
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            // carry quotient into the next division, restart remainder
            dvd_ff <= div_dvd;
            rem_ff <= '0;
            unique case (phase_ff)
               PH_X:    tx_ff <= div_rem;
               PH_Y:    ty_ff <= div_rem;
               default: tz_ff <= div_rem;
            endcase
         end else begin
            dvd_ff <= div_dvd;
            rem_ff <= div_rem;
         end
      end
      if (state_ff == F_MUL1) begin
         dxdy_ff   <= DXDY_W'(dims.dx) * DXDY_W'(dims.dy);
         rowoff_ff <= DXDY_W'(dims.dx) * DXDY_W'(ty_ff);
      end
      if (state_ff == F_MUL2) begin
         base_ff <= KNOT_W'(dxdy_ff) * KNOT_W'(tz_ff) + KNOT_W'(rowoff_ff) + KNOT_W'(tx_ff);
      end
   end

   assign q_push        = (state_ff == F_PUSH) & ~q_stat.full;
   assign q_entry.base  = base_ff;
   assign q_entry.dx    = dims.dx;
   assign q_entry.dxdy  = dxdy_ff;

endmodule

// File: design/btki_queue.sv
// Two-entry queue of tile descriptors between front and back ends.
// Depends on btki_pkg.
module btki_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_push,
   input  btki_pkg::btki_tile_type   q_entry,
   input  logic                      q_pop,
   output btki_pkg::btki_tile_type   q_head,
   output btki_pkg::btki_qstat_type  q_stat
);
   import btki_pkg::*;

   btki_tile_type mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (q_push && !q_pop)      count_ff <= count_ff + 1'b1;
         else if (q_pop && !q_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ptr_ff] <= q_entry;
   end

   assign q_head       = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

endmodule

// File: design/btki_back.sv
// Back end: walks the 4x4x4 knot block of one tile, one word per cycle while
// the receiver does not stall, into an output register. Depends on btki_pkg.
module btki_back (
   input  logic                      clock,
   input  logic                      reset,
   input  btki_pkg::btki_tile_type   q_head,
   input  btki_pkg::btki_qstat_type  q_stat,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [btki_pkg::KNOT_W-1:0] rsp_knot_index,
   output logic                      rsp_last_knot
);
   import btki_pkg::*;

   logic              active_ff, active_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [KNOT_W-1:0] idx_ff, idx_in;
   logic [KNOT_W-1:0] row_ff, row_in;
   logic [KNOT_W-1:0] plane_ff, plane_in;
   logic [DIM_W-1:0]  dx_ff, dx_in;
   logic [DXDY_W-1:0] dxdy_ff, dxdy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KNOT_W-1:0] rsp_knot_index_ff;
   logic              rsp_last_knot_ff;

   logic              out_free, emit, last;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign emit     = active_ff & out_free;
   assign last     = (cnt_ff == CNT_W'(KNOTS_PER_TILE - 1));
   // load a new tile when idle, or right behind the final word of the current one
   assign q_pop    = ~q_stat.empty & (~active_ff | (emit & last));

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      row_in    = row_ff;
      plane_in  = plane_ff;
      dx_in     = dx_ff;
      dxdy_in   = dxdy_ff;
      if (emit) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff[1:0] != 2'd3) begin
            idx_in = idx_ff + 1'b1;
         end else if (cnt_ff[3:2] != 2'd3) begin
            row_in = row_ff + KNOT_W'(dx_ff);
            idx_in = row_ff + KNOT_W'(dx_ff);
         end else begin
            plane_in = plane_ff + KNOT_W'(dxdy_ff);
            row_in   = plane_ff + KNOT_W'(dxdy_ff);
            idx_in   = plane_ff + KNOT_W'(dxdy_ff);
         end
         if (last) active_in = 1'b0;
      end
      if (q_pop) begin
         active_in = 1'b1;
         cnt_in    = '0;
         idx_in    = q_head.base;
         row_in    = q_head.base;
         plane_in  = q_head.base;
         dx_in     = q_head.dx;
         dxdy_in   = q_head.dxdy;
      end
      if (emit)           rsp_valid_in = 1'b1;
      else if (out_free)  rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      row_ff   <= row_in;
      plane_ff <= plane_in;
      dx_ff    <= dx_in;
      dxdy_ff  <= dxdy_in;
      if (emit) begin
         rsp_knot_index_ff <= idx_ff;
         rsp_last_knot_ff  <= last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_knot_index = rsp_knot_index_ff;
   assign rsp_last_knot  = rsp_last_knot_ff;

endmodule

// File: design/bspline_tile_knot_indexer.sv
// Cubic B-spline tile knot indexer.
//
// The req channel takes one tile number per word; the rsp channel returns the
// 64 linear indices of the 4x4x4 control knots the tile depends on, x fastest,
// then y, then z, with last_knot set on the 64th. Grid knot counts per axis
// sit in three CSRs (byte addresses 0, 4, 8), reset to 4 and clamped to
// 4..MAX_GRID_DIM; write them only while the block is idle.
//
// The rsp channel carries one knot word per cycle while the receiver does not
// stall, and so sets the rate. The front end takes one tile word at a time and
// splits it with three divisions (two quotient bits a cycle), the multiply
// states F_MUL1 and F_MUL2 and a push into a two-entry queue, so it runs
// ahead of the back end.
//
// Reset (synchronous, active high) empties the queue, drops any tile in flight
// and restores the CSRs. When the receiver stalls, the rsp word holds and the
// knot walk pauses; the front end keeps working until the queue fills, then
// holds its tile and keeps req stalled.
`include "bspline_tile_knot_indexer_defines.svh"

module bspline_tile_knot_indexer #(
   parameter int MAX_GRID_DIM = btki_pkg::DEF_MAX_GRID_DIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [btki_pkg::TILE_W-1:0]       req_tile_number,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [btki_pkg::KNOT_W-1:0]       rsp_knot_index,
   output logic                              rsp_last_knot,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [btki_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [btki_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [btki_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import btki_pkg::*;

   btki_dims_type  dims;
   btki_qstat_type q_stat;
   btki_tile_type  q_entry, q_head;
   logic           q_push, q_pop;

   btki_csr #(.MAX_GRID_DIM(MAX_GRID_DIM)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   btki_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_tile_number (req_tile_number),
      .req_stall       (req_stall),
      .dims            (dims),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   btki_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_stat  (q_stat)
   );

   btki_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_knot_index (rsp_knot_index),
      .rsp_last_knot  (rsp_last_knot)
   );

   `BTKI_ASSERT_NOW(a_push_has_room, q_push, !q_stat.full, "push into full tile queue")
   `BTKI_ASSERT_NOW(a_pop_has_data, q_pop, !q_stat.empty, "pop from empty tile queue")
   `BTKI_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "front took a second word while busy")

endmodule
